>>> rtl/core/afr_pkg.sv
package afr_pkg;

    // Default buffer depth in bytes
    localparam int MSG_SIZE_DEF = 32;

    // Operation codes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_POLL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Line control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LOW = 8'h20;

    localparam logic [7:0] NODE_ADDRESS_RST = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_ADDR         = 3'd1,
        PH_PAYLOAD      = 3'd2,
        PH_SKIP_PAYLOAD = 3'd3,
        PH_SKIP_REPLY   = 3'd4
    } phase_t;

    // Receiver control state
    typedef struct packed {
        phase_t phase;
        logic   escape_pending;
        logic   message_held;
    } rx_state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [4:0] read_index;
    } in_t;

    typedef struct packed {
        logic       msg_ready;
        logic [5:0] msg_length;
        logic [7:0] read_byte;
        logic [2:0] rx_phase;
        logic       overflow;
    } out_t;

endpackage

>>> rtl/core/afr_decode.sv
module afr_decode #(
    parameter int MSG_SIZE = afr_pkg::MSG_SIZE_DEF,
    parameter int WPW      = $clog2(MSG_SIZE + 1),
    parameter int AW       = (MSG_SIZE > 1) ? $clog2(MSG_SIZE) : 1
) (
    input  logic [1:0]        op,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        node_address,
    input  afr_pkg::rx_state_t cur,
    input  logic [WPW-1:0]    wpos,
    output afr_pkg::rx_state_t nxt,
    output logic [WPW-1:0]    wpos_next,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output logic              overflow
);

    logic [7:0] data_byte;

    // Unescape: a pending escape flips bit 5 of the data byte
    assign data_byte = cur.escape_pending ? (rx_byte ^ afr_pkg::CH_LOW) : rx_byte;
    assign wr_addr   = wpos[AW-1:0];
    assign wr_data   = data_byte;

    // Next-state decode for one transaction
    always_comb
    begin
        nxt       = cur;
        wpos_next = wpos;
        wr_en     = 1'b0;
        overflow  = 1'b0;
        if (op == afr_pkg::OP_BYTE)
        begin
            priority if (rx_byte == afr_pkg::CH_SOH)
            begin
                nxt.phase          = afr_pkg::PH_ADDR;
                nxt.escape_pending = 1'b0;
            end
            else if (rx_byte == afr_pkg::CH_EOT)
            begin
                if (cur.phase == afr_pkg::PH_PAYLOAD && !cur.escape_pending)
                    nxt.message_held = 1'b1;
                nxt.phase          = afr_pkg::PH_IDLE;
                nxt.escape_pending = 1'b0;
            end
            else if (rx_byte == afr_pkg::CH_STX)
            begin
                nxt.phase          = afr_pkg::PH_SKIP_REPLY;
                nxt.escape_pending = 1'b0;
            end
            else if (rx_byte == afr_pkg::CH_ETX)
            begin
                nxt.phase          = afr_pkg::PH_IDLE;
                nxt.escape_pending = 1'b0;
            end
            else if (rx_byte == afr_pkg::CH_ESC)
            begin
                nxt.escape_pending = 1'b1;
            end
            else if (!cur.escape_pending && rx_byte < afr_pkg::CH_LOW)
            begin
                // undefined control byte aborts the frame
                nxt.phase = afr_pkg::PH_IDLE;
            end
            else
            begin
                nxt.escape_pending = 1'b0;
                unique case (cur.phase)
                    afr_pkg::PH_ADDR:
                    begin
                        if (data_byte == node_address && !cur.message_held)
                        begin
                            nxt.phase = afr_pkg::PH_PAYLOAD;
                            wpos_next = '0;
                        end
                        else
                            nxt.phase = afr_pkg::PH_SKIP_PAYLOAD;
                    end
                    afr_pkg::PH_PAYLOAD:
                    begin
                        if (wpos >= WPW'(MSG_SIZE))
                        begin
                            nxt.phase = afr_pkg::PH_IDLE;
                            overflow  = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wpos_next = wpos + WPW'(1);
                        end
                    end
                    afr_pkg::PH_SKIP_PAYLOAD, afr_pkg::PH_SKIP_REPLY:
                        nxt.phase = cur.phase;
                    default:
                        nxt.phase = afr_pkg::PH_IDLE;
                endcase
            end
        end
        else if (op == afr_pkg::OP_POLL && cur.message_held)
        begin
            // release the held message
            nxt.message_held = 1'b0;
            wpos_next        = '0;
        end
    end

endmodule

>>> rtl/core/afr_buffer.sv
module afr_buffer #(
    parameter int MSG_SIZE = afr_pkg::MSG_SIZE_DEF,
    parameter int AW       = (MSG_SIZE > 1) ? $clog2(MSG_SIZE) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [4:0]    rd_index,
    output logic [7:0]    rd_data
);

    localparam int IW = (AW > 5) ? AW : 5;

    logic [7:0]    mem [0:MSG_SIZE-1];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] idx_ext;
    logic [AW-1:0] rd_addr;
    logic          in_range;

    assign idx_ext  = IW'(rd_index);
    assign rd_addr  = idx_ext[AW-1:0];
    assign in_range = ({3'b000, rd_index} < 8'(MSG_SIZE));
    assign rd_data  = rd_data_reg;

    // Payload store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read; positions past the store read as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= in_range ? mem[rd_addr] : 8'h00;
    end

endmodule

>>> rtl/core/addressed_frame_receiver.sv
// Latency: a result is valid the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the output register is reloaded in
// the same cycle it is drained, so in_ready only drops while a result stalls.
// Reset (rst_n, async, active low): phase idle, no escape, no message held,
// node address 1. The payload store is not cleared and needs no init pass.
module addressed_frame_receiver #(
    parameter int MSG_SIZE = afr_pkg::MSG_SIZE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  afr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output afr_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data
);

    localparam int WPW = $clog2(MSG_SIZE + 1);
    localparam int AW  = (MSG_SIZE > 1) ? $clog2(MSG_SIZE) : 1;

    afr_pkg::rx_state_t state_reg;
    afr_pkg::rx_state_t state_next;
    logic [WPW-1:0]     wpos_reg;
    logic [WPW-1:0]     wpos_next;
    logic [7:0]         node_address_reg;
    logic               out_valid_reg;
    afr_pkg::out_t      res_reg;
    afr_pkg::out_t      res_next;
    logic               read_sel_reg;
    logic               accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               ovf;
    logic [7:0]         rd_data;
    logic               is_poll;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign is_poll   = (in_data.op == afr_pkg::OP_POLL);

    afr_decode #(
        .MSG_SIZE (MSG_SIZE),
        .WPW      (WPW),
        .AW       (AW)
    ) u_decode (
        .op           (in_data.op),
        .rx_byte      (in_data.rx_byte),
        .node_address (node_address_reg),
        .cur          (state_reg),
        .wpos         (wpos_reg),
        .nxt          (state_next),
        .wpos_next    (wpos_next),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .overflow     (ovf)
    );

    afr_buffer #(
        .MSG_SIZE (MSG_SIZE),
        .AW       (AW)
    ) u_buffer (
        .clk      (clk),
        .wr_en    (wr_en && accept),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (accept),
        .rd_index (in_data.read_index),
        .rd_data  (rd_data)
    );

    // Result fields other than the read byte
    always_comb
    begin
        res_next            = '0;
        res_next.msg_ready  = is_poll ? state_reg.message_held : state_next.message_held;
        res_next.msg_length = (is_poll && state_reg.message_held) ? 6'(wpos_reg) : 6'd0;
        res_next.rx_phase   = state_next.phase;
        res_next.overflow   = ovf;
    end

    // The read byte is zero for every op other than a read
    always_comb
    begin
        out_data           = res_reg;
        out_data.read_byte = read_sel_reg ? rd_data : 8'h00;
    end

    // Control state, config register and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '{phase: afr_pkg::PH_IDLE, escape_pending: 1'b0,
                                  message_held: 1'b0};
            wpos_reg         <= '0;
            node_address_reg <= afr_pkg::NODE_ADDRESS_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_address_reg <= cfg_data;
            if (accept)
            begin
                state_reg <= state_next;
                wpos_reg  <= wpos_next;
            end
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg      <= res_next;
            read_sel_reg <= (in_data.op == afr_pkg::OP_READ);
        end
    end

    // Checks
    a_ovf_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.rx_phase == afr_pkg::PH_IDLE)
        else $error("overflow result without idle phase");

    a_len_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.msg_length != 6'd0 |-> out_data.msg_ready)
        else $error("message length without message ready");

    a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= WPW'(MSG_SIZE))
        else $error("write position beyond buffer");

    a_payload_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == afr_pkg::PH_PAYLOAD |-> !state_reg.message_held)
        else $error("payload phase while a message is held");

endmodule
